// ===== design/lfpd_pkg.sv =====
// Shared types, constants and the sensor pattern decoder for the line follower drive.
// No dependencies; lfpd_front, lfpd_back and the top level import this package.
package lfpd_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_BASE_SPEED = 2'd0,
    CFG_GAIN_P     = 2'd1,
    CFG_GAIN_I     = 2'd2,
    CFG_GAIN_D     = 2'd3
  } cfg_reg_t;

  localparam logic [7:0] BASE_SPEED_RST = 8'd120;
  localparam logic [7:0] GAIN_P_RST     = 8'd15;
  localparam logic [7:0] GAIN_I_RST     = 8'd10;
  localparam logic [7:0] GAIN_D_RST     = 8'd0;

  // Highest duty a boosted wheel may take.
  localparam logic [9:0] DUTY_LIMIT = 10'd250;

  // ceil(2^26 / 1000): exact truncated quotient by 1000 for magnitudes up to 32768.
  localparam logic [16:0] DIV1000_RECIP = 17'd67109;
  localparam int          DIV1000_SHIFT = 26;

  typedef struct packed {
    logic [7:0] base_speed;
    logic [7:0] gain_p;
    logic [7:0] gain_i;
    logic [7:0] gain_d;
  } cfg_t;

  typedef struct packed {
    logic               known;
    logic signed [4:0]  code;
  } pattern_t;

  // One classified sample travelling from the front to the back.
  typedef struct packed {
    logic signed [4:0]  pos;
    logic signed [4:0]  prev;
    logic signed [15:0] sum;
  } mid_item_t;

  typedef struct packed {
    logic [7:0]        left_duty;
    logic [7:0]        right_duty;
    logic signed [8:0] correction;
  } out_item_t;

  function automatic pattern_t lfpd_decode(input logic [6:0] bits);
    pattern_t p;
    p.known = 1'b1;
    unique case (bits)
      7'd1:    p.code = 5'sd12;
      7'd2:    p.code = 5'sd8;
      7'd3:    p.code = 5'sd10;
      7'd4:    p.code = 5'sd3;
      7'd6:    p.code = 5'sd6;
      7'd7:    p.code = 5'sd9;
      7'd8:    p.code = 5'sd0;
      7'd12:   p.code = 5'sd1;
      7'd14:   p.code = 5'sd2;
      7'd15:   p.code = 5'sd15;
      7'd16:   p.code = -5'sd3;
      7'd24:   p.code = -5'sd1;
      7'd28:   p.code = 5'sd0;
      7'd31:   p.code = 5'sd15;
      7'd32:   p.code = -5'sd8;
      7'd48:   p.code = -5'sd6;
      7'd56:   p.code = -5'sd2;
      7'd63:   p.code = 5'sd15;
      7'd64:   p.code = -5'sd12;
      7'd96:   p.code = -5'sd10;
      7'd112:  p.code = -5'sd9;
      7'd120:  p.code = -5'sd15;
      7'd124:  p.code = -5'sd15;
      7'd126:  p.code = -5'sd15;
      default: begin
        p.known = 1'b0;
        p.code  = 5'sd0;
      end
    endcase
    return p;
  endfunction

endpackage

// ===== design/lfpd_fifo.sv =====
// Small register-based queue with first-word fall-through read.
// Depends on nothing; DEPTH must be a power of two of at least 2.
module lfpd_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/lfpd_front.sv =====
// Front end: accepts sensor samples, decodes the line position and updates the integral.
// Depends on lfpd_pkg for the pattern decoder and the queued item type.
module lfpd_front
  import lfpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [6:0] in_sensor_bits,
  input  logic       mid_full,
  output logic       mid_push,
  output mid_item_t  mid_item
);

  logic signed [4:0]  position_r, position_nxt;
  logic signed [15:0] integral_r, integral_nxt;
  logic signed [16:0] sum_wide;
  pattern_t           pat;
  logic               accept;

  assign accept   = in_push && !mid_full;
  assign mid_push = accept;

  always_comb begin
    pat          = lfpd_decode(in_sensor_bits);
    // An unknown pattern keeps the previous position.
    position_nxt = pat.known ? pat.code : position_r;
    sum_wide     = {integral_r[15], integral_r} + {{12{position_nxt[4]}}, position_nxt};
    // Saturate when the two top bits disagree.
    if (sum_wide[16] != sum_wide[15]) begin
      integral_nxt = sum_wide[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      integral_nxt = sum_wide[15:0];
    end
    mid_item.pos  = position_nxt;
    mid_item.prev = position_r;
    mid_item.sum  = integral_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
      integral_r <= '0;
    end else if (accept) begin
      position_r <= position_nxt;
      integral_r <= integral_nxt;
    end
  end

endmodule

// ===== design/lfpd_back.sv =====
// Back end: three-stage PID datapath (divide, multiply, sum and clamp) and duty split.
// Depends on lfpd_pkg for the configuration, queued item and result types.
module lfpd_back
  import lfpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      mid_empty,
  input  mid_item_t mid_item,
  output logic      mid_pop,
  input  logic      res_full,
  output logic      res_push,
  output out_item_t res_item
);

  logic advance;

  // Stage 1: integral / 1000 magnitude, position delta.
  logic               s1_v_r;
  logic [5:0]         s1_quot_r;
  logic               s1_neg_r;
  logic signed [4:0]  s1_pos_r;
  logic signed [5:0]  s1_delta_r;
  logic signed [16:0] sum_ext;
  logic [16:0]        sum_mag;
  logic [33:0]        quot_prod;

  // Stage 2: the three gain products.
  logic               s2_v_r;
  logic signed [14:0] s2_p_r, s2_i_r, s2_d_r;
  logic signed [14:0] gp_ext, gi_ext, gd_ext, pos_ext, quot_ext, delta_ext;

  // Stage 3: clamped correction.
  logic               s3_v_r;
  logic signed [9:0]  s3_corr_r;
  logic signed [16:0] corr_raw, corr_lim, base_ext;

  // Result split.
  logic [9:0]         mag;
  logic [9:0]         up_sum;
  logic [7:0]         up;
  logic signed [10:0] down_wide;
  logic [7:0]         down;

  assign advance = !(s3_v_r && res_full);
  assign mid_pop = advance && !mid_empty;

  always_comb begin
    sum_ext   = {mid_item.sum[15], mid_item.sum};
    sum_mag   = sum_ext[16] ? 17'(-sum_ext) : 17'(sum_ext);
    quot_prod = sum_mag * DIV1000_RECIP;
  end

  always_comb begin
    gp_ext    = {7'b0, cfg.gain_p};
    gi_ext    = {7'b0, cfg.gain_i};
    gd_ext    = {7'b0, cfg.gain_d};
    pos_ext   = {{10{s1_pos_r[4]}}, s1_pos_r};
    delta_ext = {{9{s1_delta_r[5]}}, s1_delta_r};
    quot_ext  = s1_neg_r ? -{9'b0, s1_quot_r} : {9'b0, s1_quot_r};
  end

  always_comb begin
    base_ext = {9'b0, cfg.base_speed};
    corr_raw = {{2{s2_p_r[14]}}, s2_p_r} + {{2{s2_i_r[14]}}, s2_i_r}
             + {{2{s2_d_r[14]}}, s2_d_r};
    // Upper limit is tested first, then the lower one on the result.
    corr_lim = (corr_raw > base_ext) ? (base_ext - 17'sd1) : corr_raw;
    if (corr_lim < -base_ext) begin
      corr_lim = 17'sd1 - base_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (advance) begin
      s1_v_r <= !mid_empty;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_quot_r  <= quot_prod[DIV1000_SHIFT+5:DIV1000_SHIFT];
      s1_neg_r   <= mid_item.sum[15];
      s1_pos_r   <= mid_item.pos;
      s1_delta_r <= {mid_item.pos[4], mid_item.pos} - {mid_item.prev[4], mid_item.prev};
      s2_p_r     <= gp_ext * pos_ext;
      s2_i_r     <= gi_ext * quot_ext;
      s2_d_r     <= gd_ext * delta_ext;
      s3_corr_r  <= corr_lim[9:0];
    end
  end

  always_comb begin
    mag       = s3_corr_r[9] ? 10'(-s3_corr_r) : 10'(s3_corr_r);
    up_sum    = {2'b0, cfg.base_speed} + mag;
    up        = (up_sum > DUTY_LIMIT) ? cfg.base_speed : up_sum[7:0];
    down_wide = {3'b0, cfg.base_speed} - {1'b0, mag};
    down      = down_wide[10] ? 8'd0 : down_wide[7:0];

    res_item.correction = s3_corr_r[8:0];
    if (s3_corr_r == '0) begin
      res_item.left_duty  = cfg.base_speed;
      res_item.right_duty = cfg.base_speed;
    end else if (!s3_corr_r[9]) begin
      res_item.left_duty  = up;
      res_item.right_duty = down;
    end else begin
      res_item.left_duty  = down;
      res_item.right_duty = up;
    end
    res_push = s3_v_r && !res_full;
  end

endmodule

// ===== design/line_follower_pid_drive.sv =====
// Top level of the PID line follower motor drive.
// Depends on lfpd_pkg, lfpd_front, lfpd_fifo and lfpd_back.
//
// Usage: each input beat carries one 7-bit line sensor pattern on in_sensor_bits and
// is taken when in_push is high and in_full is low. Every beat yields exactly one
// result beat: two wheel PWM duties and the clamped signed PID correction. The oldest
// result sits on the out_ ports while out_empty is low and leaves on a cycle with
// out_pop high.
// The front end decodes the pattern and updates position and integral state at the
// moment of acceptance, so samples may arrive on every cycle while in_full is low. A
// four-entry queue sits between the front end and the three-stage back end (divide by
// 1000, gain products, sum and clamp). A result passes the middle queue, the three
// back end stage registers and the result queue, and one beat per cycle is sustained
// while the receiver keeps popping.
// When the receiver stops popping, the result queue fills, the back end holds its
// stages, the middle queue fills and finally in_full rises; nothing is dropped.
// Configuration writes on the cfg_ port are always taken (cfg_ready is tied high)
// and are meant to happen only while the block is idle. Synchronous reset restores
// the default gains and base speed, clears position and integral and empties queues.
module line_follower_pid_drive
  import lfpd_pkg::*;
#(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic [6:0]        in_sensor_bits,
  output logic              in_full,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [7:0]        out_left_duty,
  output logic [7:0]        out_right_duty,
  output logic signed [8:0] out_correction,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data
);

  cfg_t      cfg_r;
  mid_item_t front_item, mid_head;
  logic      mid_push, mid_pop, mid_full, mid_empty;
  out_item_t back_item, res_head;
  logic      res_push, res_full;

  // Configuration registers; a write is always accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_speed <= BASE_SPEED_RST;
      cfg_r.gain_p     <= GAIN_P_RST;
      cfg_r.gain_i     <= GAIN_I_RST;
      cfg_r.gain_d     <= GAIN_D_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_BASE_SPEED: cfg_r.base_speed <= cfg_data;
        CFG_GAIN_P:     cfg_r.gain_p     <= cfg_data;
        CFG_GAIN_I:     cfg_r.gain_i     <= cfg_data;
        CFG_GAIN_D:     cfg_r.gain_d     <= cfg_data;
      endcase
    end
  end

  // Input is refused only when the middle queue is full.
  assign in_full = mid_full;

  lfpd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_sensor_bits (in_sensor_bits),
    .mid_full       (mid_full),
    .mid_push       (mid_push),
    .mid_item       (front_item)
  );

  lfpd_fifo #(
    .W     ($bits(mid_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .din   (front_item),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_head),
    .empty (mid_empty)
  );

  lfpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .mid_empty (mid_empty),
    .mid_item  (mid_head),
    .mid_pop   (mid_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (back_item)
  );

  // The result queue parts the back end from the receiver.
  lfpd_fifo #(
    .W     ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (back_item),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_head),
    .empty (out_empty)
  );

  assign out_left_duty  = res_head.left_duty;
  assign out_right_duty = res_head.right_duty;
  assign out_correction = res_head.correction;

endmodule
